// ----- hw/rtl/ytr_pkg.sv -----
// shared types and constants for the yuyv to rgb converter
`timescale 1ns / 1ps

package ytr_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_SCALE    = 2'd2;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [8:0]  DIM_SCALE_RST    = 9'd220;

  // q16 coefficients, sized for the 27 bit signed sums
  localparam int SUM_W = 27;
  localparam logic signed [SUM_W-1:0] K_RV = 27'sd89831;
  localparam logic signed [SUM_W-1:0] K_GV = 27'sd45744;
  localparam logic signed [SUM_W-1:0] K_GU = 27'sd22127;
  localparam logic signed [SUM_W-1:0] K_BU = 27'sd113538;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;

  localparam int POS_W = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             frame_end;
  } pos_t;

endpackage

// ----- hw/rtl/ytr_color_conv.sv -----
// yuv to rgb conversion of one pixel with clamping to 0..255
`timescale 1ns / 1ps

module ytr_color_conv import ytr_pkg::*; (
  input  logic [7:0] luma,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  output rgb_t       rgb
);

  function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (|s[SUM_W-2:24]) begin
      r = 8'd255;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

  logic signed [8:0]       d_u;
  logic signed [8:0]       d_v;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;

  always_comb begin
    d_u   = $signed({1'b0, chroma_blue} - CHROMA_OFFSET);
    d_v   = $signed({1'b0, chroma_red} - CHROMA_OFFSET);
    base  = $signed({3'b000, luma, 16'h0000});
    sum_r = base + K_RV * SUM_W'(d_v);
    sum_g = base - K_GV * SUM_W'(d_v) - K_GU * SUM_W'(d_u);
    sum_b = base + K_BU * SUM_W'(d_u);
    rgb.red   = clamp_q16(sum_r);
    rgb.green = clamp_q16(sum_g);
    rgb.blue  = clamp_q16(sum_b);
  end

endmodule

// ----- hw/rtl/ytr_dimmer.sv -----
// brightness scaling of one rgb pixel by scale/256 with cap at 255
`timescale 1ns / 1ps

module ytr_dimmer import ytr_pkg::*; (
  input  rgb_t       rgb_in,
  input  logic [8:0] dim_scale,
  output rgb_t       rgb_out
);

  function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [8:0] s);
    logic [16:0] prod;
    logic [7:0]  r;
    prod = 17'(c) * 17'(s);
    r = prod[16] ? 8'd255 : prod[15:8];
    return r;
  endfunction

  always_comb begin
    rgb_out.red   = dim_channel(rgb_in.red, dim_scale);
    rgb_out.green = dim_channel(rgb_in.green, dim_scale);
    rgb_out.blue  = dim_channel(rgb_in.blue, dim_scale);
  end

endmodule

// ----- hw/rtl/ytr_position.sv -----
// row and column counters with wrap at the frame bounds and end of frame flag
`timescale 1ns / 1ps

module ytr_position import ytr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [11:0] frame_width,
  input  logic [11:0] frame_height,
  output pos_t        pos
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WW0 > 12) ? WW0 : 12;
  localparam int HW  = (HW0 > 12) ? HW0 : 12;

  logic [CW-1:0] column;
  logic [CW-1:0] column_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [WW-1:0] eff_width;
  logic [WW-1:0] width_in;
  logic [HW-1:0] eff_height;
  logic [HW-1:0] height_in;
  logic [CW:0]   column_inc;
  logic [RW:0]   row_inc;
  logic [31:0]   column_ext;
  logic [31:0]   row_ext;

  always_comb begin
    width_in = WW'(frame_width);
    if (width_in < WW'(2)) begin
      eff_width = WW'(2);
    end else if (width_in > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = width_in;
    end
    eff_width[0] = 1'b0;

    height_in = HW'(frame_height);
    if (height_in < HW'(1)) begin
      eff_height = HW'(1);
    end else if (height_in > HW'(MAX_HEIGHT)) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = height_in;
    end

    column_inc  = {1'b0, column} + (CW+1)'(1);
    row_inc     = {1'b0, row} + (RW+1)'(1);
    column_next = column_inc[CW-1:0];
    row_next    = row;
    if (WW'(column_inc) >= eff_width) begin
      column_next = '0;
      row_next    = (HW'(row_inc) >= eff_height) ? '0 : row_inc[RW-1:0];
    end

    column_ext    = 32'(column);
    row_ext       = 32'(row);
    pos.column    = column_ext[POS_W-1:0];
    pos.row       = row_ext[POS_W-1:0];
    pos.frame_end = (HW'(row) == eff_height - HW'(1)) &&
                    (WW'(column) == eff_width - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

// ----- hw/rtl/yuyv_to_rgb_dimmed_top.sv -----
// top level of the yuyv 4:2:2 to dimmed rgb888 pixel stream converter
`timescale 1ns / 1ps

// Each accepted YUYV word gives two RGB pixels, the Y0 pixel first, one
// result transaction per cycle while the output is not stalled; the block
// takes the next word as the Y1 pixel of the held word moves on, and the
// input register holds the word while its two pixels go out in turn. The Y0
// pixel passes from the input register through colour conversion and
// dimming into the output register, and the Y1 pixel follows it as the
// next output transaction.
// Configuration writes take effect at once and belong between frames with
// the stream idle.
module yuyv_to_rgb_dimmed_top import ytr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [31:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // red, green, blue, row, column, zero fill
  output logic [47:0]            m_tdata,
  // second_of_pair
  output logic                   m_tuser,
  output logic                   m_tlast
);

  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [8:0]  dim_scale;

  logic        advance;
  logic        s_accept;
  logic        s0_valid;
  logic        s0_phase;
  logic [31:0] s0_data;
  logic [7:0]  s0_luma;
  rgb_t        conv_rgb;
  pos_t        cur_pos;
  rgb_t        dim_rgb;

  rgb_t        out_rgb;
  pos_t        out_pos;
  logic        out_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      dim_scale    <= DIM_SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_DIM_SCALE:    dim_scale    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s0_valid || (advance && s0_phase);
  assign s_accept = s_tvalid && s_tready;

  // input register, emits the y0 pixel then the y1 pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_phase <= 1'b0;
    end else if (s_accept) begin
      s0_valid <= 1'b1;
      s0_phase <= 1'b0;
    end else if (advance && s0_valid) begin
      if (s0_phase) begin
        s0_valid <= 1'b0;
        s0_phase <= 1'b0;
      end else begin
        s0_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s0_data <= s_tdata;
    end
  end

  assign s0_luma = s0_phase ? s0_data[23:16] : s0_data[7:0];

  ytr_color_conv u_conv (
    .luma        (s0_luma),
    .chroma_blue (s0_data[15:8]),
    .chroma_red  (s0_data[31:24]),
    .rgb         (conv_rgb)
  );

  ytr_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance && s0_valid),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pos          (cur_pos)
  );

  ytr_dimmer u_dim (
    .rgb_in    (conv_rgb),
    .dim_scale (dim_scale),
    .rgb_out   (dim_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rgb    <= dim_rgb;
      out_pos    <= cur_pos;
      out_second <= s0_phase;
    end
  end

  assign m_tdata = {2'b00, out_pos.column, out_pos.row,
                    out_rgb.blue, out_rgb.green, out_rgb.red};
  assign m_tuser = out_second;
  assign m_tlast = out_pos.frame_end;

  // no new word is taken while the y1 pixel of the held word is still pending
  assert property (@(posedge clk) disable iff (rst)
    s_tready && s0_valid |-> s0_phase)
    else $error("input accepted before second pixel issued");

  // a y0 pixel on the output has its partner waiting in the input register
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> s0_valid && s0_phase)
    else $error("y0 pixel without its y1 partner");

  // the y0 pixel moving on always turns the held word to its second phase
  assert property (@(posedge clk) disable iff (rst)
    s0_valid && !s0_phase && advance |=> s0_valid && s0_phase)
    else $error("phase did not advance to y1");

  // a stalled output transaction holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("output changed while stalled");

endmodule
